@@ sv/pdbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Press duration bank selector package
// Shared types, register codes and reset values for the bank selector.
// ----------------------------------------------------------------------------
package pdbs_pkg;

    localparam int unsigned CfgIndexWidth = 3;

    localparam logic [7:0] LONG_PRESS_RST  = 8'd200;
    localparam logic [7:0] SHORT_MAX_RST   = 8'd100;
    localparam logic [7:0] FLASH_RST       = 8'd10;
    localparam logic [7:0] RESET_LOW_RST   = 8'd25;
    localparam logic [7:0] RESET_GUARD_RST = 8'd25;
    localparam logic [1:0] POWER_BANK_RST  = 2'd0;
    localparam logic [7:0] RESET_DARK_TICKS = 8'd5;

    localparam logic [1:0] LED_DARK = 2'd0;
    localparam logic [1:0] LED_WAIT = 2'd1;
    localparam logic [1:0] LED_ON   = 2'd3;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_LONG_PRESS  = 3'd0,
        CFG_SHORT_MAX   = 3'd1,
        CFG_FLASH       = 3'd2,
        CFG_RESET_LOW   = 3'd3,
        CFG_RESET_GUARD = 3'd4,
        CFG_POWER_BANK  = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_RESET_LOW  = 3'd0,
        PH_GUARD      = 3'd1,
        PH_IDLE       = 3'd2,
        PH_FLASH_IDLE = 3'd3,
        PH_WAIT_REL   = 3'd4,
        PH_SELECT     = 3'd5,
        PH_FLASH_SEL  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] short_press_max;
        logic [7:0] flash_ticks;
        logic [7:0] reset_low_ticks;
        logic [7:0] reset_guard_ticks;
        logic [1:0] power_on_bank;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic [1:0] bank;
    } bank_load_t;

    // Packed so that bank_select sits in the lowest bits.
    typedef struct packed {
        logic [1:0] save_bank;
        logic       save_strobe;
        logic       reset_active;
        logic [1:0] led_pattern;
        logic [1:0] bank_select;
    } result_t;

endpackage

@@ sv/press_duration_bank_selector_core.sv @@
// ----------------------------------------------------------------------------
// Press duration bank selector
// Counts key press ticks to pick one of four ROM banks, flashes the LEDs,
// requests a save of the chosen bank and runs a machine reset pulse.
//
//   Channel   Direction  Contents
//   s_axis    in         one key sample per transaction
//   m_axis    out        one result per accepted key sample
//   cfg       in         register write, no read-back
//
// At the edge that accepts a key sample, the state is updated and the result
// is registered, and it shows on m_axis in the next cycle. One sample can
// be taken in every cycle while the output side keeps up; a held result
// stalls the input only once the output register is full and m_axis_tready
// is low. Reset puts the block in the reset-low phase with all thresholds
// at their defaults.
// ----------------------------------------------------------------------------
module press_duration_bank_selector_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] key_pressed
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] bank_select, [3:2] led_pattern, [4] reset_active,
    // [5] save_strobe, [7:6] save_bank
    output logic [7:0]                         m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [pdbs_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [7:0]                         cfg_data
);
    import pdbs_pkg::*;

    cfg_t       cfg;
    bank_load_t bank_load;
    result_t    result;
    result_t    out_data;
    logic       step;

    assign step = s_axis_tvalid && s_axis_tready;

    pdbs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .bank_load (bank_load)
    );

    pdbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .key       (s_axis_tdata[0]),
        .cfg       (cfg),
        .bank_load (bank_load),
        .result    (result)
    );

    pdbs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .result    (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule

@@ sv/pdbs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the timing thresholds and the power-up bank written over the
// configuration port.
// ----------------------------------------------------------------------------
module pdbs_cfg_regs (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [pdbs_pkg::CfgIndexWidth-1:0]        cfg_index,
    input  logic [7:0]                                cfg_data,
    output pdbs_pkg::cfg_t                            cfg,
    output pdbs_pkg::bank_load_t                      bank_load
);
    import pdbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic load_next;

    always_comb
    begin
        cfg_next  = cfg_reg;
        load_next = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LONG_PRESS:  cfg_next.long_press_ticks  = cfg_data;
                CFG_SHORT_MAX:   cfg_next.short_press_max   = cfg_data;
                CFG_FLASH:       cfg_next.flash_ticks       = cfg_data;
                CFG_RESET_LOW:   cfg_next.reset_low_ticks   = cfg_data;
                CFG_RESET_GUARD: cfg_next.reset_guard_ticks = cfg_data;
                CFG_POWER_BANK:
                begin
                    cfg_next.power_on_bank = cfg_data[1:0];
                    load_next              = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= LONG_PRESS_RST;
            cfg_reg.short_press_max   <= SHORT_MAX_RST;
            cfg_reg.flash_ticks       <= FLASH_RST;
            cfg_reg.reset_low_ticks   <= RESET_LOW_RST;
            cfg_reg.reset_guard_ticks <= RESET_GUARD_RST;
            cfg_reg.power_on_bank     <= POWER_BANK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg            = cfg_reg;
    assign bank_load.load = load_next;
    assign bank_load.bank = cfg_data[1:0];

endmodule

@@ sv/pdbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bank selector control
// Phase state machine, press counter and bank registers; computes the
// result of one key sample and advances the state when the sample is taken.
// ----------------------------------------------------------------------------
module pdbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 key,
    input  pdbs_pkg::cfg_t       cfg,
    input  pdbs_pkg::bank_load_t bank_load,
    output pdbs_pkg::result_t    result
);
    import pdbs_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] timer_reg, timer_next;
    logic [1:0] chosen_reg, chosen_next;
    logic [1:0] stored_reg, stored_next;
    logic [1:0] active_reg, active_next;
    logic       last_reg;

    logic       pair;
    logic       strobe;
    logic [7:0] timer_inc;
    logic [7:0] count_sat;
    logic [1:0] led;

    always_comb
    begin
        pair        = key & last_reg;
        timer_inc   = timer_reg + 8'd1;
        count_sat   = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
        phase_next  = phase_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        chosen_next = chosen_reg;
        stored_next = stored_reg;
        active_next = active_reg;
        strobe      = 1'b0;

        unique case (phase_reg)
            PH_RESET_LOW:
            begin
                if (timer_inc >= cfg.reset_low_ticks)
                begin
                    timer_next = 8'd0;
                    phase_next = (cfg.reset_guard_ticks == 8'd0) ? PH_IDLE : PH_GUARD;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            PH_GUARD:
            begin
                if (timer_inc >= cfg.reset_guard_ticks)
                begin
                    timer_next = 8'd0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            PH_FLASH_IDLE:
            begin
                if (timer_inc >= cfg.flash_ticks)
                begin
                    timer_next = 8'd0;
                    phase_next = PH_WAIT_REL;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            PH_WAIT_REL:
            begin
                if (!pair)
                begin
                    chosen_next = stored_reg;
                    count_next  = 8'd0;
                    phase_next  = PH_SELECT;
                end
            end
            PH_SELECT:
            begin
                if (pair)
                begin
                    if (count_sat >= cfg.long_press_ticks)
                    begin
                        count_next = 8'd0;
                        timer_next = 8'd0;
                        if (cfg.flash_ticks == 8'd0)
                        begin
                            stored_next = chosen_reg;
                            active_next = chosen_reg;
                            strobe      = 1'b1;
                            phase_next  = PH_RESET_LOW;
                        end
                        else
                        begin
                            phase_next = PH_FLASH_SEL;
                        end
                    end
                    else
                    begin
                        count_next = count_sat;
                    end
                end
                else
                begin
                    count_next = 8'd0;
                    if (count_reg != 8'd0 && count_reg <= cfg.short_press_max)
                    begin
                        chosen_next = chosen_reg + 2'd1;
                    end
                end
            end
            PH_FLASH_SEL:
            begin
                if (timer_inc >= cfg.flash_ticks)
                begin
                    stored_next = chosen_reg;
                    active_next = chosen_reg;
                    strobe      = 1'b1;
                    timer_next  = 8'd0;
                    phase_next  = PH_RESET_LOW;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            default:
            begin
                // Idle, and the unused code, which falls back to idle.
                phase_next = PH_IDLE;
                if (pair)
                begin
                    if (count_sat >= cfg.long_press_ticks)
                    begin
                        count_next = 8'd0;
                        timer_next = 8'd0;
                        phase_next = (cfg.flash_ticks == 8'd0) ? PH_WAIT_REL : PH_FLASH_IDLE;
                    end
                    else
                    begin
                        count_next = count_sat;
                    end
                end
                else
                begin
                    count_next = 8'd0;
                end
            end
        endcase

        unique case (phase_next)
            PH_RESET_LOW:  led = (timer_next < RESET_DARK_TICKS) ? LED_DARK : LED_ON;
            PH_FLASH_IDLE: led = LED_DARK;
            PH_FLASH_SEL:  led = LED_DARK;
            PH_WAIT_REL:   led = LED_WAIT;
            PH_SELECT:     led = chosen_next;
            default:       led = LED_ON;
        endcase

        result.bank_select  = active_next;
        result.led_pattern  = led;
        result.reset_active = (phase_next == PH_RESET_LOW);
        result.save_strobe  = strobe;
        result.save_bank    = strobe ? stored_next : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RESET_LOW;
            count_reg  <= 8'd0;
            timer_reg  <= 8'd0;
            chosen_reg <= POWER_BANK_RST;
            stored_reg <= POWER_BANK_RST;
            active_reg <= POWER_BANK_RST;
            last_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            timer_reg  <= timer_next;
            chosen_reg <= chosen_next;
            stored_reg <= stored_next;
            active_reg <= active_next;
            last_reg   <= key;
        end
        else if (bank_load.load)
        begin
            chosen_reg <= bank_load.bank;
            stored_reg <= bank_load.bank;
            active_reg <= bank_load.bank;
        end
    end

endmodule

@@ sv/pdbs_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the output side takes it, and lets a new
// key sample in whenever the register is empty or being emptied.
// ----------------------------------------------------------------------------
module pdbs_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdbs_pkg::result_t result,
    output logic              out_valid,
    input  logic              out_ready,
    output pdbs_pkg::result_t out_data
);
    import pdbs_pkg::*;

    logic    valid_reg;
    result_t data_reg;
    logic    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/pdbs_checker.sv @@
// ----------------------------------------------------------------------------
// Bank selector port checker
// Watches the top-level ports for results that the selector can never give.
// ----------------------------------------------------------------------------
module pdbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A save always starts a machine reset in the same transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("save strobe without reset");

    // The saved bank is driven onto the bank lines at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[1:0] == m_axis_tdata[7:6])
        else $error("saved bank differs from bank lines");

    // Without a save the save bank field reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[7:6] == 2'd0)
        else $error("save bank set without strobe");

    // During reset the LEDs are either all dark or all lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4]
            |-> m_axis_tdata[3:2] == 2'd0 || m_axis_tdata[3:2] == 2'd3)
        else $error("bad LED pattern during reset");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind press_duration_bank_selector_core pdbs_checker u_pdbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Press duration bank selector testbench
// Feeds key samples to the selector core over its input stream and checks
// every result against a cycle-free model of the key handling kept in this
// file. Directed tests cover the power-up defaults, the short and long press
// limits, zero and full-scale settings and the spare register indexes.
// Random press gestures then run under two register settings while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import pdbs_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        PRESS_NONE,
        PRESS_LONG,
        PRESS_RELEASE
    } press_event_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_style_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [7:0]               m_axis_tdata;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [7:0]               cfg_data;

    // Model of the selector state and its registers.
    cfg_t       sel_cfg;
    phase_t     sel_phase;
    logic [7:0] sel_count;
    logic [7:0] sel_timer;
    logic [1:0] sel_chosen;
    logic [1:0] sel_stored;
    logic [1:0] sel_active;
    logic       sel_last_key;

    result_t    awaited_outputs[$];
    int         mismatches = 0;
    int         keys_sent = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    int         ready_span = 0;
    ready_style_t ready_style = READY_ALWAYS;

    press_duration_bank_selector_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic press_event_t count_presses(input logic pair, output logic [7:0] held);
        held = 8'd0;
        if (pair)
        begin
            if (sel_count != 8'hFF)
                sel_count = sel_count + 8'd1;
            if (sel_count >= sel_cfg.long_press_ticks)
            begin
                sel_count = 8'd0;
                return PRESS_LONG;
            end
            return PRESS_NONE;
        end
        held = sel_count;
        sel_count = 8'd0;
        if (held != 8'd0)
            return PRESS_RELEASE;
        return PRESS_NONE;
    endfunction

    function automatic result_t next_selector_outputs(input logic key);
        logic         pair;
        logic         commit;
        logic [7:0]   held;
        press_event_t ev;
        result_t      res;
        pair = key && sel_last_key;
        commit = 1'b0;
        case (sel_phase)
            PH_RESET_LOW:
            begin
                sel_timer = sel_timer + 8'd1;
                if (sel_timer >= sel_cfg.reset_low_ticks)
                begin
                    sel_timer = 8'd0;
                    if (sel_cfg.reset_guard_ticks == 8'd0)
                        sel_phase = PH_IDLE;
                    else
                        sel_phase = PH_GUARD;
                end
            end
            PH_GUARD:
            begin
                sel_timer = sel_timer + 8'd1;
                if (sel_timer >= sel_cfg.reset_guard_ticks)
                begin
                    sel_timer = 8'd0;
                    sel_phase = PH_IDLE;
                end
            end
            PH_FLASH_IDLE:
            begin
                sel_timer = sel_timer + 8'd1;
                if (sel_timer >= sel_cfg.flash_ticks)
                begin
                    sel_timer = 8'd0;
                    sel_phase = PH_WAIT_REL;
                end
            end
            PH_WAIT_REL:
            begin
                if (!pair)
                begin
                    sel_chosen = sel_stored;
                    sel_count = 8'd0;
                    sel_phase = PH_SELECT;
                end
            end
            PH_SELECT:
            begin
                ev = count_presses(pair, held);
                if (ev == PRESS_LONG)
                begin
                    sel_timer = 8'd0;
                    if (sel_cfg.flash_ticks == 8'd0)
                        commit = 1'b1;
                    else
                        sel_phase = PH_FLASH_SEL;
                end
                else if (ev == PRESS_RELEASE && held <= sel_cfg.short_press_max)
                begin
                    sel_chosen = sel_chosen + 2'd1;
                end
            end
            PH_FLASH_SEL:
            begin
                sel_timer = sel_timer + 8'd1;
                if (sel_timer >= sel_cfg.flash_ticks)
                    commit = 1'b1;
            end
            default:
            begin
                sel_phase = PH_IDLE;
                if (count_presses(pair, held) == PRESS_LONG)
                begin
                    sel_timer = 8'd0;
                    if (sel_cfg.flash_ticks == 8'd0)
                        sel_phase = PH_WAIT_REL;
                    else
                        sel_phase = PH_FLASH_IDLE;
                end
            end
        endcase
        if (commit)
        begin
            sel_stored = sel_chosen;
            sel_active = sel_chosen;
            sel_phase = PH_RESET_LOW;
            sel_timer = 8'd0;
        end
        sel_last_key = key;

        case (sel_phase)
            PH_RESET_LOW:  res.led_pattern = (sel_timer < RESET_DARK_TICKS) ? LED_DARK : LED_ON;
            PH_FLASH_IDLE: res.led_pattern = LED_DARK;
            PH_FLASH_SEL:  res.led_pattern = LED_DARK;
            PH_WAIT_REL:   res.led_pattern = LED_WAIT;
            PH_SELECT:     res.led_pattern = sel_chosen;
            default:       res.led_pattern = LED_ON;
        endcase
        res.bank_select = sel_active;
        res.reset_active = (sel_phase == PH_RESET_LOW);
        res.save_strobe = commit;
        res.save_bank = commit ? sel_stored : 2'd0;
        return res;
    endfunction

    task automatic check_selector_output(input result_t got);
        result_t want;
        if (awaited_outputs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("Unexpected transaction on the output: %h", got);
        end
        else
        begin
            want = awaited_outputs.pop_front();
            if (got.bank_select !== want.bank_select || got.led_pattern !== want.led_pattern ||
                got.reset_active !== want.reset_active || got.save_strobe !== want.save_strobe ||
                got.save_bank !== want.save_bank)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("Mismatch: expected %0d/%0d/%b/%b/%0d got %0d/%0d/%b/%b/%0d",
                             want.bank_select, want.led_pattern, want.reset_active,
                             want.save_strobe, want.save_bank, got.bank_select,
                             got.led_pattern, got.reset_active, got.save_strobe, got.save_bank);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_selector_output(result_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                awaited_outputs.push_back(next_selector_outputs(s_axis_tdata[0]));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_span = $urandom_range(8, 64);
        end
        ready_span--;
        case (ready_style)
            READY_ALWAYS:   m_axis_tready <= 1'b1;
            READY_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_axis_tready <= (ready_span % 3 != 0);
            default:        m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_key(input logic key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        keys_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input logic key, input int count);
        repeat (count) send_key(key);
    endtask

    // Holds the key for the given number of counted press ticks, then releases.
    task automatic press_key(input int ticks, input int release_len);
        send_run(1'b1, ticks + 1);
        send_run(1'b0, release_len);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_LONG_PRESS:  sel_cfg.long_press_ticks = value;
            CFG_SHORT_MAX:   sel_cfg.short_press_max = value;
            CFG_FLASH:       sel_cfg.flash_ticks = value;
            CFG_RESET_LOW:   sel_cfg.reset_low_ticks = value;
            CFG_RESET_GUARD: sel_cfg.reset_guard_ticks = value;
            CFG_POWER_BANK:
            begin
                sel_cfg.power_on_bank = value[1:0];
                sel_chosen = value[1:0];
                sel_stored = value[1:0];
                sel_active = value[1:0];
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_selector(input logic [7:0] long_ticks, input logic [7:0] short_max,
                                    input logic [7:0] flash, input logic [7:0] low_ticks,
                                    input logic [7:0] guard, input logic [1:0] bank);
        wait_drained();
        write_reg(CFG_LONG_PRESS, long_ticks);
        write_reg(CFG_SHORT_MAX, short_max);
        write_reg(CFG_FLASH, flash);
        write_reg(CFG_RESET_LOW, low_ticks);
        write_reg(CFG_RESET_GUARD, guard);
        write_reg(CFG_POWER_BANK, {6'd0, bank});
        cfg_we <= 1'b0;
    endtask

    task automatic test_power_up_defaults();
        send_run(1'b0, 51);
        // The long press ends on the last key-down sample; the release then
        // covers the flash time and enters selection.
        press_key(200, 12);
        press_key(1, 1);
    endtask

    task automatic test_press_limits();
        program_selector(8'd6, 8'd3, 8'd2, 8'd6, 8'd2, 2'd2);
        send_run(1'b0, 2);
        press_key(2, 1);
        press_key(9, 1);
        press_key(1, 1);
        press_key(3, 1);
        press_key(4, 1);
        press_key(5, 1);
        send_key(1'b1);
        send_key(1'b0);
        send_key(1'b1);
        send_key(1'b0);
        press_key(8, 0);
        // Key kept down through the reset pulse and guard time into idle.
        send_run(1'b1, 20);
        send_run(1'b0, 2);
    endtask

    task automatic test_zero_settings();
        program_selector(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 2'd1);
        send_run(1'b0, 3);
        press_key(1, 1);
        press_key(1, 1);
        press_key(0, 2);
        press_key(1, 2);
        press_key(2, 2);
        // Short limit above the long limit.
        program_selector(8'd3, 8'd5, 8'd1, 8'd1, 8'd1, 2'd3);
        send_run(1'b0, 4);
        press_key(4, 1);
        press_key(2, 1);
        press_key(1, 1);
        press_key(3, 1);
        send_run(1'b0, 4);
    endtask

    task automatic test_full_scale();
        program_selector(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3);
        send_run(1'b0, 3);
        press_key(10, 2);
    endtask

    task automatic test_spare_indexes();
        wait_drained();
        write_reg(CFG_SPARE_LO, 8'($urandom));
        write_reg(CFG_SPARE_HI, 8'($urandom));
        cfg_we <= 1'b0;
        press_key(3, 2);
    endtask

    task automatic test_random_gestures();
        int stop_at;
        int long_len;
        int short_len;
        for (int set = 0; set < 2; set++)
        begin
            if (set == 0)
                program_selector(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 2'($urandom));
            else
                program_selector(8'($urandom_range(2, 12)), 8'($urandom_range(1, 15)),
                                 8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)),
                                 8'($urandom_range(0, 4)), 2'($urandom));
            long_len = int'(sel_cfg.long_press_ticks);
            short_len = int'(sel_cfg.short_press_max);
            stop_at = keys_sent + 30;
            while (keys_sent < stop_at)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: press_key($urandom_range(1, short_len), $urandom_range(1, 3));
                    3:       press_key(short_len + $urandom_range(1, 3), $urandom_range(1, 3));
                    4, 5:    press_key(long_len + $urandom_range(0, 6), $urandom_range(1, 3));
                    6:       repeat ($urandom_range(1, 8)) send_key(1'($urandom));
                    7:       send_run(1'b0, $urandom_range(1, 10));
                    8:       press_key(0, 1);
                    default: press_key(2 * long_len + $urandom_range(0, 12), 0);
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LONG_PRESS;
        cfg_data = 8'd0;
        sel_cfg.long_press_ticks = LONG_PRESS_RST;
        sel_cfg.short_press_max = SHORT_MAX_RST;
        sel_cfg.flash_ticks = FLASH_RST;
        sel_cfg.reset_low_ticks = RESET_LOW_RST;
        sel_cfg.reset_guard_ticks = RESET_GUARD_RST;
        sel_cfg.power_on_bank = POWER_BANK_RST;
        sel_phase = PH_RESET_LOW;
        sel_count = 8'd0;
        sel_timer = 8'd0;
        sel_chosen = POWER_BANK_RST;
        sel_stored = POWER_BANK_RST;
        sel_active = POWER_BANK_RST;
        sel_last_key = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_power_up_defaults();
        test_press_limits();
        test_zero_settings();
        test_full_scale();
        test_spare_indexes();
        test_random_gestures();

        wait_drained();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pdbs_pkg.sv
sv/pdbs_cfg_regs.sv
sv/pdbs_ctrl.sv
sv/pdbs_out_reg.sv
sv/press_duration_bank_selector_core.sv
sv/pdbs_checker.sv
dv/tb_top.sv
